>>> hw/rtl/stdf_pkg.sv
`default_nettype none

package stdf_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned TypeWidth = 16;
   localparam int unsigned LenWidth  = 32;
   localparam int unsigned SyncWidth = 16;

   localparam logic [SyncWidth-1:0] SyncWordReset = 16'hCAFE;

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_BAD_SYNC = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_SYNC_HI = 4'd0,
      PH_SYNC_LO = 4'd1,
      PH_TYPE_HI = 4'd2,
      PH_TYPE_LO = 4'd3,
      PH_LEN_0   = 4'd4,
      PH_LEN_1   = 4'd5,
      PH_LEN_2   = 4'd6,
      PH_LEN_3   = 4'd7,
      PH_PAYLOAD = 4'd8
   } phase_type;

   // One step of the frame parser: whether it gives a result, and that result.
   typedef struct packed {
      logic                 emit;
      kind_type             kind;
      logic [TypeWidth-1:0] msg_type;
      logic [ByteWidth-1:0] payload_byte;
      logic                 last;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/stdf_req_if.sv
`default_nettype none

interface stdf_req_if import stdf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stdf_rsp_if.sv
`default_nettype none

interface stdf_rsp_if import stdf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [TypeWidth-1:0] msg_type;
   logic [ByteWidth-1:0] payload_byte;
   logic                 last;

   modport source (output valid, output kind, output msg_type, output payload_byte,
                   output last, input ready);
   modport sink (input valid, input kind, input msg_type, input payload_byte,
                 input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stdf_frame_fsm.sv
`default_nettype none

module stdf_frame_fsm import stdf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [ByteWidth-1:0] rx_byte,
   input  wire logic [SyncWidth-1:0] sync_word,
   output      result_type           result
);

   phase_type            phase_ff,  phase_in;
   logic [ByteWidth-1:0] header_ff, header_in;
   logic [TypeWidth-1:0] type_ff,   type_in;
   logic [LenWidth-1:0]  left_ff,   left_in;

   logic [TypeWidth-1:0] word;
   logic [LenWidth-1:0]  len_shift;
   logic                 fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC_HI;
         header_ff <= '0;
         type_ff   <= '0;
         left_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         type_ff   <= type_in;
         left_ff   <= left_in;
      end
   end

   assign word      = {header_ff, rx_byte};
   assign len_shift = {left_ff[LenWidth-ByteWidth-1:0], rx_byte};
   assign fin       = (left_ff <= LenWidth'(1));

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      type_in   = type_ff;
      left_in   = left_ff;
      result    = '{emit: 1'b0, kind: KIND_DATA, msg_type: '0, payload_byte: '0,
                    last: 1'b0};
      if (step) begin
         unique case (phase_ff)
            PH_SYNC_LO: begin
               if (word != sync_word) begin
                  // Both sync bytes are dropped; the search restarts at the next byte.
                  phase_in    = PH_SYNC_HI;
                  result.emit = 1'b1;
                  result.kind = KIND_BAD_SYNC;
               end else begin
                  phase_in = PH_TYPE_HI;
               end
            end
            PH_TYPE_HI: begin
               header_in = rx_byte;
               phase_in  = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
               type_in  = word;
               phase_in = PH_LEN_0;
            end
            PH_LEN_0: begin
               left_in  = len_shift;
               phase_in = PH_LEN_1;
            end
            PH_LEN_1: begin
               left_in  = len_shift;
               phase_in = PH_LEN_2;
            end
            PH_LEN_2: begin
               left_in  = len_shift;
               phase_in = PH_LEN_3;
            end
            PH_LEN_3: begin
               left_in = len_shift;
               if (len_shift == '0) begin
                  phase_in        = PH_SYNC_HI;
                  result.emit     = 1'b1;
                  result.kind     = KIND_EMPTY;
                  result.msg_type = type_ff;
                  result.last     = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               result.emit         = 1'b1;
               result.kind         = KIND_DATA;
               result.msg_type     = type_ff;
               result.payload_byte = rx_byte;
               result.last         = fin;
               left_in             = fin ? '0 : left_ff - LenWidth'(1);
               if (fin) begin
                  phase_in = PH_SYNC_HI;
               end
            end
            default: begin
               // First sync byte; codes that cannot arise land here as well.
               header_in = rx_byte;
               phase_in  = PH_SYNC_LO;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/sync_type_length_deframer_unit.sv
`default_nettype none

// Channel   Direction  Carries                                   Transfer when
// req_chan  in         rx_byte                                   valid && ready
// rsp_chan  out        kind, msg_type, payload_byte, last        valid && ready
// csr       in         sync_word (csr_wdata)                     csr_we
//
// One byte is accepted per cycle while req_chan.ready is high; its result passes
// through the input register and then the result register around the parser.
// Header bytes give no result, so the result stream is never faster than the input.
// Reset is synchronous and restores the sync word to 0xCAFE and the parser
// to the start of a sync word.
// A stalled result holds the result register; the input register then holds
// its byte, and req_chan.ready falls only when both are occupied and the
// result is not being taken.

module sync_type_length_deframer_unit import stdf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   stdf_req_if.sink                  req_chan,
   stdf_rsp_if.source                rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [SyncWidth-1:0] csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_res_ff;
   logic [SyncWidth-1:0] sync_ff;

   logic       out_free;
   logic       advance;
   logic       req_take;
   result_type step_res;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || out_free;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? step_res.emit : (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sync_ff      <= SyncWordReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            sync_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && step_res.emit) begin
         out_res_ff <= step_res;
      end
   end

   stdf_frame_fsm u_frame_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .sync_word (sync_ff),
      .result    (step_res)
   );

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_res_ff.kind;
   assign rsp_chan.msg_type     = out_res_ff.msg_type;
   assign rsp_chan.payload_byte = out_res_ff.payload_byte;
   assign rsp_chan.last         = out_res_ff.last;

   // A byte waiting in the input register must not be lost or altered.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input byte dropped while stalled");

   // A bad-sync result carries neither a type nor a last mark.
   a_bad_sync: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.kind == KIND_BAD_SYNC |->
      out_res_ff.msg_type == '0 && out_res_ff.payload_byte == '0 && !out_res_ff.last)
      else $error("bad-sync result with stray fields");

   // An empty message always closes its frame and has no payload.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.kind == KIND_EMPTY |->
      out_res_ff.last && out_res_ff.payload_byte == '0)
      else $error("empty message without last mark");

   // A result is only loaded when the register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
